/* rtl/bkrd_pkg.sv */
// ----------------------------------------------------------------------------
// bkrd_pkg - shared types and constants of the keyboard report differ
// Report layout, register codes, event batch type and the usage mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package bkrd_pkg;

	localparam int MAX_SLOTS   = 6;
	localparam int USAGE_W     = 8;
	localparam int LEN_W       = 4;
	localparam int EVENT_MAX   = 2 * MAX_SLOTS;
	localparam int IN_FIELD_W  = LEN_W + MAX_SLOTS * USAGE_W;
	localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 2 * USAGE_W;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;

	localparam logic [LEN_W-1:0]   FULL_REPORT_BYTES  = 4'd8;
	localparam logic [USAGE_W-1:0] USAGE_LETTER_FIRST = 8'h04;
	localparam logic [USAGE_W-1:0] USAGE_LETTER_LAST  = 8'h1D;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LETTER_BASE  = 1'b0,
		REG_UNKNOWN_CODE = 1'b1
	} cfg_reg_t;

	typedef logic [USAGE_W-1:0] usage_t;

	// bits 0..MAX_SLOTS-1: key-down per new slot, the rest: key-up per old slot
	typedef struct packed {
		logic [EVENT_MAX-1:0]   mask;
		usage_t [EVENT_MAX-1:0] usage;
	} batch_t;

	typedef struct packed {
		usage_t letter_base;
		usage_t unknown_code;
	} cfg_t;

	function automatic usage_t map_usage(input usage_t usage, input cfg_t cfg);
		usage_t offset;
		offset = usage - USAGE_LETTER_FIRST;
		if (usage >= USAGE_LETTER_FIRST && usage <= USAGE_LETTER_LAST) begin
			return cfg.letter_base + offset;
		end
		return cfg.unknown_code;
	endfunction

endpackage

`default_nettype wire

/* rtl/bkrd_diff.sv */
// ----------------------------------------------------------------------------
// bkrd_diff - set difference of two keycode reports
// Flags new slots absent from the old set and old keys absent from the new.
// ----------------------------------------------------------------------------
`default_nettype none

module bkrd_diff
	import bkrd_pkg::*;
#(
	parameter int KEY_SLOTS = MAX_SLOTS
) (
	input  usage_t [MAX_SLOTS-1:0] slots,
	input  usage_t [KEY_SLOTS-1:0] prev,
	output batch_t                 batch
);

	always_comb begin
		usage_t [MAX_SLOTS-1:0] now;
		logic hit;
		batch = '0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			now[i] = (i < KEY_SLOTS) ? slots[i] : '0;
		end
		// key-down: nonzero new slot not held before
		for (int i = 0; i < MAX_SLOTS; i++) begin
			hit = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (prev[j] == now[i]) hit = 1'b1;
			end
			batch.mask[i]  = (now[i] != '0) && !hit;
			batch.usage[i] = now[i];
		end
		// key-up: nonzero old key missing from the new report
		for (int i = 0; i < KEY_SLOTS; i++) begin
			hit = 1'b0;
			for (int j = 0; j < MAX_SLOTS; j++) begin
				if (now[j] == prev[i]) hit = 1'b1;
			end
			batch.mask[MAX_SLOTS+i]  = (prev[i] != '0) && !hit;
			batch.usage[MAX_SLOTS+i] = prev[i];
		end
	end

endmodule

`default_nettype wire

/* rtl/bkrd_emit.sv */
// ----------------------------------------------------------------------------
// bkrd_emit - event sequencer and output register
// Holds one batch of pending events and sends them out one item per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bkrd_emit
	import bkrd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   bat_valid,
	input  batch_t                 bat,
	output logic                   bat_ready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // key_index [7:0], raw_usage [15:8]
	output logic                   m_tlast,   // last_of_run
	output logic                   m_tuser    // pressed
);

	logic [EVENT_MAX-1:0]   mask_q;
	usage_t [EVENT_MAX-1:0] usage_q;
	logic                   out_valid_q;
	usage_t                 key_index_q;
	usage_t                 raw_usage_q;
	logic                   pressed_q;
	logic                   last_q;

	logic [EVENT_MAX-1:0] pick;
	logic [EVENT_MAX-1:0] rest;
	usage_t               sel_usage;
	logic                 has_ev;
	logic                 is_last;
	logic                 load_out;
	logic                 take;

	always_comb begin
		pick      = mask_q & (~mask_q + 1'b1);
		rest      = mask_q & ~pick;
		sel_usage = '0;
		for (int i = 0; i < EVENT_MAX; i++) begin
			sel_usage = sel_usage | (pick[i] ? usage_q[i] : '0);
		end
		has_ev    = |mask_q;
		is_last   = (rest == '0);
		load_out  = has_ev && (!out_valid_q || m_tready);
		bat_ready = !has_ev || (load_out && is_last);
		take      = bat_valid && bat_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (take) begin
			mask_q <= bat.mask;
		end else if (load_out) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			usage_q <= bat.usage;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			key_index_q <= map_usage(sel_usage, cfg);
			raw_usage_q <= sel_usage;
			pressed_q   <= |pick[MAX_SLOTS-1:0];
			last_q      <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {raw_usage_q, key_index_q};
	assign m_tlast  = last_q;
	assign m_tuser  = pressed_q;

	// pending events only drain unless a fresh batch is taken
	a_mask_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> (mask_q & ~$past(mask_q)) == '0)
		else $error("pending event appeared without a batch");

	// sending the final event of a batch empties the sequencer
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && is_last && !take |=> mask_q == '0)
		else $error("events left after the final one was sent");

endmodule

`default_nettype wire

/* rtl/boot_keyboard_report_diff.sv */
// ----------------------------------------------------------------------------
// boot_keyboard_report_diff - boot keyboard report to key event converter
// Compares each full report with the previous one and streams key events.
// ----------------------------------------------------------------------------
// A report item is taken into an input register; reports shorter than eight
// bytes are dropped there and change nothing. A full report is compared with
// the stored previous key set in a single combinational pass, and its events
// (key-down for new slots in slot order, then key-up for released keys in slot
// order, duplicates kept) are handed as one batch to the sequencer, which
// sends one event per cycle while the receiver is ready, through an output
// register; the final event of a report carries tlast. A report with n events
// (0 to 12) occupies the sequencer until all n are sent, and a new report may
// enter every cycle while the sequencer is free, so the single output port
// sets the throughput. Letter usages 0x04 to 0x1D map to letter_base plus
// offset (modulo 256); every other usage maps to unknown_code. Write the two
// registers only while no events are pending.
`default_nettype none

module boot_keyboard_report_diff
	import bkrd_pkg::*;
#(
	parameter int KEY_SLOTS = MAX_SLOTS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// report_length [3:0], key_slot_0 [11:4] .. key_slot_5 [51:44]
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// key_index [7:0], raw_usage [15:8]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast,   // last_of_run
	output logic                   m_tuser,   // pressed
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t                   cfg_q;
	usage_t [KEY_SLOTS-1:0] prev_q;

	logic                   valid_s1;
	logic [LEN_W-1:0]       len_s1;
	usage_t [MAX_SLOTS-1:0] slots_s1;

	batch_t batch;
	logic   full_s1;
	logic   bat_valid;
	logic   bat_ready;
	logic   consume;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.letter_base  <= 8'd0;
			cfg_q.unknown_code <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LETTER_BASE:  cfg_q.letter_base  <= cfg_data;
				REG_UNKNOWN_CODE: cfg_q.unknown_code <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register: accept whenever it is empty or drains this cycle
	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			len_s1 <= s_tdata[LEN_W-1:0];
			for (int i = 0; i < MAX_SLOTS; i++) begin
				slots_s1[i] <= s_tdata[LEN_W + USAGE_W*i +: USAGE_W];
			end
		end
	end

	bkrd_diff #(
		.KEY_SLOTS (KEY_SLOTS)
	) u_diff (
		.slots (slots_s1),
		.prev  (prev_q),
		.batch (batch)
	);

	// short reports and reports with no change never wait for the sequencer
	assign full_s1   = (len_s1 >= FULL_REPORT_BYTES);
	assign bat_valid = valid_s1 && full_s1 && (|batch.mask);
	assign consume   = valid_s1 && (!bat_valid || bat_ready);

	// advance the previous key set on every full report that leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (consume && full_s1) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_q[i] <= slots_s1[i];
			end
		end
	end

	bkrd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.bat_valid (bat_valid),
		.bat       (batch),
		.bat_ready (bat_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	// the key set moves only when a report leaves the input register
	a_prev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!consume |=> $stable(prev_q))
		else $error("previous key set changed without a report");

endmodule

`default_nettype wire

/* bench/tb_boot_keyboard_report_diff.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_boot_keyboard_report_diff - self-checking bench of the report differ
// Streams boot keyboard reports into the block and predicts the key events for
// each accepted item. Every event leaving the block is compared field by field
// with the oldest prediction. Directed cases come first, then random traffic
// under several idling and stall patterns and several mapping settings.
// ----------------------------------------------------------------------------

module tb_boot_keyboard_report_diff;
	import bkrd_pkg::*;

	typedef usage_t [MAX_SLOTS-1:0] report_keys_t;

	typedef struct packed {
		usage_t key_index;
		usage_t raw_usage;
		logic   pressed;
		logic   last_of_run;
	} key_event_t;

	// Cycles to hold after the last event before touching the mapping
	// registers: a report with no events may still sit in the input stage.
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 20000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   m_tuser;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Predictor state: mapping registers and the key set of the last full report
	usage_t       letter_base_q = 8'h00;
	usage_t       unknown_code_q = 8'hFF;
	report_keys_t held_keys = '0;

	// Events predicted but not yet seen on the output, oldest first
	key_event_t pending_events[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;

	boot_keyboard_report_diff dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Receiver: stall at random according to the current phase
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Event checker: compare every accepted event with the oldest prediction
	always @(posedge clk) begin
		key_event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				$error("unexpected event: key_index %0h raw_usage %0h pressed %0b last %0b",
					m_tdata[7:0], m_tdata[15:8], m_tuser, m_tlast);
				fail_count++;
			end else begin
				want = pending_events.pop_front();
				if (m_tdata[7:0] !== want.key_index) begin
					$error("key_index: expected %0h, got %0h", want.key_index, m_tdata[7:0]);
					fail_count++;
				end
				if (m_tdata[15:8] !== want.raw_usage) begin
					$error("raw_usage: expected %0h, got %0h", want.raw_usage, m_tdata[15:8]);
					fail_count++;
				end
				if (m_tuser !== want.pressed) begin
					$error("pressed: expected %0b, got %0b", want.pressed, m_tuser);
					fail_count++;
				end
				if (m_tlast !== want.last_of_run) begin
					$error("last_of_run: expected %0b, got %0b", want.last_of_run, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Build a key set with slot 0 written first
	function automatic report_keys_t keys6(usage_t k0, usage_t k1, usage_t k2,
		usage_t k3, usage_t k4, usage_t k5);
		report_keys_t keys;
		keys[0] = k0;
		keys[1] = k1;
		keys[2] = k2;
		keys[3] = k3;
		keys[4] = k4;
		keys[5] = k5;
		return keys;
	endfunction

	function automatic bit set_has(report_keys_t set, usage_t usage);
		bit found;
		found = 1'b0;
		for (int j = 0; j < MAX_SLOTS; j++) begin
			if (set[j] == usage) begin
				found = 1'b1;
			end
		end
		return found;
	endfunction

	function automatic usage_t key_index_of(usage_t usage);
		usage_t idx;
		if (usage >= USAGE_LETTER_FIRST && usage <= USAGE_LETTER_LAST) begin
			idx = letter_base_q + (usage - USAGE_LETTER_FIRST);
		end else begin
			idx = unknown_code_q;
		end
		return idx;
	endfunction

	// Work out the events of one accepted report and advance the held key set
	function automatic void predict_report(logic [LEN_W-1:0] len, report_keys_t now);
		key_event_t batch [2*MAX_SLOTS];
		int n;
		n = 0;
		if (len < FULL_REPORT_BYTES) begin
			return;
		end
		// key-down for new usages, in slot order
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if (now[i] != 0 && !set_has(held_keys, now[i])) begin
				batch[n] = '{key_index_of(now[i]), now[i], 1'b1, 1'b0};
				n++;
			end
		end
		// key-up for released usages, in slot order of the old set
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if (held_keys[i] != 0 && !set_has(now, held_keys[i])) begin
				batch[n] = '{key_index_of(held_keys[i]), held_keys[i], 1'b0, 1'b0};
				n++;
			end
		end
		for (int k = 0; k < n; k++) begin
			batch[k].last_of_run = (k == n - 1);
			pending_events.push_back(batch[k]);
		end
		held_keys = now;
	endfunction

	// Offer one report item; idle first at random, hold until it is taken
	task automatic send_report(logic [LEN_W-1:0] len, report_keys_t keys);
		logic [IN_TDATA_W-1:0] word;
		word = '0;
		word[LEN_W-1:0] = len;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			word[LEN_W + USAGE_W*i +: USAGE_W] = keys[i];
		end
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do begin
			@(posedge clk);
		end while (!s_tready);
		predict_report(len, keys);
	endtask

	task automatic wait_drained();
		while (pending_events.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Drop the valid, let every event out and let the pipeline settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both mapping registers while the block is idle
	task automatic set_mapping(usage_t base, usage_t unknown);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_LETTER_BASE;
		cfg_data  <= base;
		@(posedge clk);
		letter_base_q = base;
		cfg_index <= REG_UNKNOWN_CODE;
		cfg_data  <= unknown;
		@(posedge clk);
		unknown_code_q = unknown;
		cfg_we <= 1'b0;
	endtask

	// ---- directed tests -------------------------------------------------

	// Letter range edges and usages just outside it, then release all
	task automatic test_press_release();
		send_report(4'd8, keys6(8'h04, 8'h1D, 8'h00, 8'h03, 8'h1E, 8'hFF));
		send_report(4'd8, keys6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
	endtask

	// Short reports are dropped: the full one after them still sees no keys held
	task automatic test_short_reports();
		send_report(4'd0, keys6(8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66));
		send_report(4'd7, keys6(8'h05, 8'h06, 8'h00, 8'h00, 8'h00, 8'h80));
		send_report(4'd8, keys6(8'h05, 8'h06, 8'h00, 8'h00, 8'h00, 8'h80));
	endtask

	// Lengths above eight count as full reports
	task automatic test_overlong_length();
		send_report(4'd9, keys6(8'h00, 8'h06, 8'h07, 8'h00, 8'h00, 8'h80));
		send_report(4'd15, keys6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
	endtask

	// A usage repeated across slots gives one key-down per slot, and a release only once no slot holds it
	task automatic test_duplicate_slots();
		send_report(4'd8, keys6(8'h05, 8'h05, 8'h05, 8'h00, 8'h00, 8'h01));
		send_report(4'd8, keys6(8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(4'd8, keys6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
	endtask

	// An unchanged full report gives no events but is still stored
	task automatic test_unchanged_report();
		send_report(4'd8, keys6(8'h2A, 8'h00, 8'h1C, 8'h00, 8'hE0, 8'h00));
		send_report(4'd8, keys6(8'h2A, 8'h00, 8'h1C, 8'h00, 8'hE0, 8'h00));
		send_report(4'd8, keys6(8'h00, 8'h00, 8'h1C, 8'h00, 8'h00, 8'h00));
	endtask

	// Six new keys replacing six old ones: twelve events in one run; hold the
	// next report back until every event has come out
	task automatic test_full_turnover();
		send_report(4'd8, keys6(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
		send_report(4'd8, keys6(8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F));
		s_tvalid <= 1'b0;
		wait_drained();
		send_report(4'd8, keys6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
	endtask

	// Letter base near the top so the offset wraps past 255
	task automatic test_letter_wrap();
		set_mapping(8'hF0, 8'h00);
		send_report(4'd8, keys6(8'h04, 8'h0F, 8'h1D, 8'h1C, 8'h00, 8'h02));
		send_report(4'd8, keys6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
	endtask

	// ---- random traffic -------------------------------------------------

	// Often keys from the held set, so presses and releases mix
	function automatic usage_t pick_slot();
		int r;
		r = $urandom_range(99);
		if (r < 30) begin
			return 8'h00;
		end else if (r < 60) begin
			return held_keys[$urandom_range(MAX_SLOTS-1)];
		end else if (r < 85) begin
			return usage_t'($urandom_range(USAGE_LETTER_LAST, USAGE_LETTER_FIRST));
		end
		return usage_t'($urandom_range(255));
	endfunction

	task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
		logic [LEN_W-1:0] len;
		report_keys_t     keys;
		int               r;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int k = 0; k < count; k++) begin
			// now and then hold the sender until the block has gone quiet
			if ($urandom_range(99) < 3) begin
				s_tvalid <= 1'b0;
				wait_drained();
			end
			r = $urandom_range(99);
			if (r < 12) begin
				len = LEN_W'($urandom_range(FULL_REPORT_BYTES - 1));
			end else if (r < 22) begin
				len = LEN_W'($urandom_range(15, FULL_REPORT_BYTES + 1));
			end else begin
				len = FULL_REPORT_BYTES;
			end
			if ($urandom_range(99) < 6) begin
				keys = held_keys;
			end else begin
				for (int i = 0; i < MAX_SLOTS; i++) begin
					keys[i] = pick_slot();
				end
			end
			send_report(len, keys);
		end
	endtask

	// ---- main sequence --------------------------------------------------

	initial begin
		int guard;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_press_release();
		test_short_reports();
		test_overlong_length();
		test_duplicate_slots();
		test_unchanged_report();
		test_full_turnover();
		test_letter_wrap();

		set_mapping(8'h00, 8'hFF);
		test_random_traffic(80, 0, 0);
		set_mapping(8'hFF, 8'h00);
		test_random_traffic(80, 65, 0);
		set_mapping(usage_t'($urandom_range(255)), usage_t'($urandom_range(255)));
		test_random_traffic(80, 0, 65);
		set_mapping(8'hE6, usage_t'($urandom_range(255)));
		test_random_traffic(80, 9, 9);

		// Drain: let every predicted event arrive, then let the block settle
		s_tvalid <= 1'b0;
		guard = 0;
		while (pending_events.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (pending_events.size() != 0) begin
			$error("%0d predicted events never arrived", pending_events.size());
			fail_count++;
		end

		if (fail_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
rtl/bkrd_pkg.sv
rtl/bkrd_diff.sv
rtl/bkrd_emit.sv
rtl/boot_keyboard_report_diff.sv
bench/tb_boot_keyboard_report_diff.sv
